@@ design/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Field widths, operation codes and the stored entry format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skt_pkg;

	localparam int KEY_W   = 16;
	localparam int PAY_W   = 32;
	localparam int COUNT_W = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FIND   = 1'b1;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [PAY_W-1:0] payload_t;

	typedef struct packed {
		key_t     key;
		payload_t payload;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ design/skt_ram.sv @@
// ----------------------------------------------------------------------------
// skt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/sorted_key_table_core.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_core: table of key and payload entries in ascending key order
// Find: busy while it visits every stored entry, not busy when empty; done follows the last busy cycle.
// Insert: not busy when full or empty, else busy while each larger entry shifts up, then the new entry is written.
// Both go through the single read port of the entry RAM, visited one entry a cycle.
// Results are strobed on done for one cycle and cannot be stalled; a new start may be taken then.
// Reset empties the table; entry contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_table_core
	import skt_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [KEY_W-1:0]   item_key,
	input  logic [PAY_W-1:0]   item_payload,
	output logic               done,
	output logic               success,
	output logic [PAY_W-1:0]   found_payload,
	output logic [COUNT_W-1:0] entry_count
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_INS   = 2'd1;
	localparam logic [1:0] ST_PLACE = 2'd2;
	localparam logic [1:0] ST_FIND  = 2'd3;

	logic [1:0]   state_q, state_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [CW-1:0] ptr_q, ptr_d;
	key_t         key_q;
	payload_t     payload_q;
	logic         hit_q, hit_d;
	payload_t     found_q, found_d;

	logic         done_q, done_d;
	logic         success_q, success_d;
	payload_t     out_payload_q, out_payload_d;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [CW-1:0] rd_ptr;
	logic [AW-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t        rd_entry;

	logic accept;
	logic key_gt;
	logic key_eq;
	logic table_full;
	logic last_find;
	entry_t new_entry;

	assign accept     = start && !busy;
	assign busy       = (state_q != ST_IDLE);
	assign rd_entry   = entry_t'(ram_rdata);
	assign key_gt     = (rd_entry.key > key_q);
	assign key_eq     = (rd_entry.key == key_q);
	assign table_full = (fill_q == CW'(TABLE_DEPTH));
	assign last_find  = (ptr_q == (fill_q - CW'(1)));
	assign new_entry  = '{key: key_q, payload: payload_q};

	always_comb begin
		state_d       = state_q;
		fill_d        = fill_q;
		ptr_d         = ptr_q;
		hit_d         = hit_q;
		found_d       = found_q;
		done_d        = 1'b0;
		success_d     = success_q;
		out_payload_d = out_payload_q;
		ram_we        = 1'b0;
		ram_waddr     = ptr_q[AW-1:0];
		ram_wdata     = new_entry;
		rd_ptr        = ptr_q;

		case (state_q)
			ST_IDLE: begin
				rd_ptr = fill_q - CW'(1);
				if (accept) begin
					hit_d   = 1'b0;
					found_d = '0;
					if (operation == OP_INSERT) begin
						if (table_full) begin
							done_d        = 1'b1;
							success_d     = 1'b0;
							out_payload_d = '0;
						end else if (fill_q == '0) begin
							ram_we        = 1'b1;
							ram_waddr     = '0;
							ram_wdata     = '{key: item_key, payload: item_payload};
							fill_d        = fill_q + CW'(1);
							done_d        = 1'b1;
							success_d     = 1'b1;
							out_payload_d = '0;
						end else begin
							ptr_d   = fill_q;
							state_d = ST_INS;
						end
					end else begin
						if (fill_q == '0) begin
							done_d        = 1'b1;
							success_d     = 1'b0;
							out_payload_d = '0;
						end else begin
							rd_ptr  = '0;
							ptr_d   = '0;
							state_d = ST_FIND;
						end
					end
				end
			end
			ST_INS: begin
				rd_ptr = ptr_q - CW'(2);
				if (key_gt) begin
					ram_we    = 1'b1;
					ram_wdata = rd_entry;
					ptr_d     = ptr_q - CW'(1);
					if (ptr_q == CW'(1)) begin
						state_d = ST_PLACE;
					end
				end else begin
					ram_we        = 1'b1;
					fill_d        = fill_q + CW'(1);
					done_d        = 1'b1;
					success_d     = 1'b1;
					out_payload_d = '0;
					state_d       = ST_IDLE;
				end
			end
			ST_PLACE: begin
				ram_we        = 1'b1;
				fill_d        = fill_q + CW'(1);
				done_d        = 1'b1;
				success_d     = 1'b1;
				out_payload_d = '0;
				state_d       = ST_IDLE;
			end
			ST_FIND: begin
				rd_ptr  = ptr_q + CW'(1);
				hit_d   = hit_q | key_eq;
				found_d = key_eq ? rd_entry.payload : found_q;
				if (last_find) begin
					done_d        = 1'b1;
					success_d     = hit_d;
					out_payload_d = found_d;
					state_d       = ST_IDLE;
				end else begin
					ptr_d = ptr_q + CW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign ram_raddr = rd_ptr[AW-1:0];

	skt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q         <= ptr_d;
		hit_q         <= hit_d;
		found_q       <= found_d;
		success_q     <= success_d;
		out_payload_q <= out_payload_d;
		if (accept) begin
			key_q     <= item_key;
			payload_q <= item_payload;
		end
	end

	assign done          = done_q;
	assign success       = success_q;
	assign found_payload = out_payload_q;
	assign entry_count   = COUNT_W'(fill_q);

`ifndef SYNTHESIS
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_DEPTH))
		else $error("fill count exceeds table depth");

	a_find_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIND) |-> !ram_we)
		else $error("RAM written during a find");

	a_ins_ptr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) |-> (ptr_q != '0))
		else $error("insert shift pointer reached zero inside shift loop");

	a_done_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(busy) || $past(start)))
		else $error("result strobe without an operation in progress");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (done_q && success_q))
		else $error("fill count changed without a successful insert");
`endif

endmodule
